// ===== sv/char_class_token_segmenter_defines.svh =====
// Assertion macros shared by the checker of the token segmenter.
// Depends on nothing; include once per file that asserts.
`ifndef CHAR_CLASS_TOKEN_SEGMENTER_DEFINES_SVH
`define CHAR_CLASS_TOKEN_SEGMENTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define CTT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("segmenter check failed");

// Next-cycle implication, disabled while reset is low.
`define CTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("segmenter check failed");

`endif

// ===== sv/ctt_pkg.sv =====
// Types, codes and byte-class helpers for the token segmenter.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package ctt_pkg;

    localparam int OUT_COL_BITS  = 12;
    localparam int OUT_LINE_BITS = 16;

    localparam logic [1:0] KIND_WORD     = 2'd0;
    localparam logic [1:0] KIND_SYMBOL   = 2'd1;
    localparam logic [1:0] KIND_LINE_END = 2'd2;

    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    typedef struct packed {
        logic [1:0]               kind;
        logic [OUT_LINE_BITS-1:0] line_number;
        logic [OUT_COL_BITS-1:0]  start_column;
        logic [OUT_COL_BITS-1:0]  length;
        logic                     last_of_run;
    } t_result;

    // All results caused by one byte; second is used only when two is set.
    typedef struct packed {
        logic    two;
        t_result first;
        t_result second;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return (c >= 8'd48 && c <= 8'd57) || (c >= 8'd65 && c <= 8'd90) ||
               (c >= 8'd97 && c <= 8'd122) || (c == CH_UNDERSCORE);
    endfunction

endpackage

// ===== sv/ctt_if.sv =====
// Stream interfaces of the token segmenter: source bytes in, tokens out.
// Depends on nothing.
`timescale 1ns / 1ps

interface ctt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_text;

    modport source (output valid, ch, end_of_text, input ready);
    modport sink   (input valid, ch, end_of_text, output ready);
endinterface

interface ctt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] line_number;
    logic [11:0] start_column;
    logic [11:0] length;
    logic        last_of_run;

    modport source (output valid, kind, line_number, start_column, length, last_of_run,
                    input ready);
    modport sink   (input valid, kind, line_number, start_column, length, last_of_run,
                    output ready);
endinterface

// ===== sv/char_class_token_segmenter.sv =====
// Top level of the character-class token segmenter: front end, queue, back end.
// Depends on ctt_pkg, ctt_if, ctt_front, ctt_queue and ctt_back.
//
//   channel   dir  handshake     payload
//   i_in      in   valid/ready   ch, end_of_text
//   o_out     out  valid/ready   kind, line_number, start_column, length, last_of_run
//
// One byte is accepted per cycle while the four-entry result queue has room.
// Results leave at one per cycle from the output register while the receiver
// is ready; a byte that closes a run and ends a line, or a non-blank byte
// that closes a run and ends the text, yields two results. Synchronous
// active-low reset clears run, column and line state and empties the
// queue. Output stalls fill the queue and then hold off input.
`timescale 1ns / 1ps

module char_class_token_segmenter import ctt_pkg::*; #(
    parameter int COLUMN_BITS = 12,
    parameter int LINE_BITS   = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ctt_in_if.sink    i_in,
    ctt_out_if.source o_out
);

    t_queue_status queue_status;
    t_entry        push_entry, head_entry;
    logic          push, pop;

    ctt_front #(
        .COLUMN_BITS (COLUMN_BITS),
        .LINE_BITS   (LINE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_status (queue_status),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    ctt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_head   (head_entry),
        .o_status (queue_status)
    );

    ctt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (queue_status),
        .i_head   (head_entry),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule

// ===== sv/ctt_front.sv =====
// Front end: accepts source bytes, classifies them, tracks run, column and
// line state, and pushes the results of each byte into the queue. Uses ctt_pkg.
`timescale 1ns / 1ps

module ctt_front import ctt_pkg::*; #(
    parameter int COLUMN_BITS = 12,
    parameter int LINE_BITS   = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ctt_in_if.sink        i_in,
    input  t_queue_status i_status,
    output logic          o_push,
    output t_entry        o_entry
);

    localparam logic [COLUMN_BITS-1:0] COL_MAX  = {COLUMN_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};

    logic                   r_in_run, n_in_run;
    logic                   r_run_is_symbol, n_run_is_symbol;
    logic [COLUMN_BITS-1:0] r_run_start, n_run_start;
    logic [COLUMN_BITS-1:0] r_column, n_column;
    logic [LINE_BITS-1:0]   r_line_count, n_line_count;

    logic                   accept;
    logic                   blank, newline, sym, eot;
    logic                   close_run, has_second;
    logic [COLUMN_BITS-1:0] col_inc;
    logic [COLUMN_BITS-1:0] flush_start;
    logic [COLUMN_BITS:0]   flush_diff;
    logic [COLUMN_BITS-1:0] flush_len;
    t_result                close_res, second_res;

    assign i_in.ready = !i_status.full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        blank      = is_blank(i_in.ch);
        newline    = (i_in.ch == CH_NEWLINE);
        sym        = !is_word(i_in.ch);
        eot        = i_in.end_of_text;
        close_run  = r_in_run && (blank || (sym != r_run_is_symbol));
        has_second = blank ? newline : eot;
        col_inc    = (r_column != COL_MAX) ? r_column + 1'b1 : r_column;

        // The flushed run may start at this very byte.
        flush_start = (r_in_run && !close_run) ? r_run_start : r_column;
        flush_diff  = {1'b0, r_column} + 1'b1 - {1'b0, flush_start};
        flush_len   = flush_diff[COLUMN_BITS] ? COL_MAX : flush_diff[COLUMN_BITS-1:0];

        close_res.kind         = r_run_is_symbol ? KIND_SYMBOL : KIND_WORD;
        close_res.line_number  = OUT_LINE_BITS'(r_line_count);
        close_res.start_column = OUT_COL_BITS'(r_run_start);
        close_res.length       = OUT_COL_BITS'(r_column - r_run_start);
        close_res.last_of_run  = !has_second;

        if (blank) begin
            second_res.kind         = KIND_LINE_END;
            second_res.start_column = OUT_COL_BITS'(r_column);
            second_res.length       = '0;
        end else begin
            second_res.kind         = sym ? KIND_SYMBOL : KIND_WORD;
            second_res.start_column = OUT_COL_BITS'(flush_start);
            second_res.length       = OUT_COL_BITS'(flush_len);
        end
        second_res.line_number = OUT_LINE_BITS'(r_line_count);
        second_res.last_of_run = 1'b1;

        o_push       = accept && (close_run || has_second);
        o_entry.two  = close_run && has_second;
        o_entry.first  = close_run ? close_res : second_res;
        o_entry.second = second_res;

        n_in_run        = r_in_run;
        n_run_is_symbol = r_run_is_symbol;
        n_run_start     = r_run_start;
        n_column        = r_column;
        n_line_count    = r_line_count;
        if (eot) begin
            n_in_run        = 1'b0;
            n_run_is_symbol = 1'b0;
            n_run_start     = '0;
            n_column        = '0;
            n_line_count    = '0;
        end else if (blank) begin
            n_in_run = 1'b0;
            if (newline) begin
                n_column     = '0;
                n_line_count = (r_line_count != LINE_MAX) ? r_line_count + 1'b1
                                                          : r_line_count;
            end else begin
                n_column = col_inc;
            end
        end else begin
            n_in_run = 1'b1;
            if (!r_in_run || close_run) begin
                n_run_is_symbol = sym;
                n_run_start     = r_column;
            end
            n_column = col_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_run        <= 1'b0;
            r_run_is_symbol <= 1'b0;
            r_run_start     <= '0;
            r_column        <= '0;
            r_line_count    <= '0;
        end else if (accept) begin
            r_in_run        <= n_in_run;
            r_run_is_symbol <= n_run_is_symbol;
            r_run_start     <= n_run_start;
            r_column        <= n_column;
            r_line_count    <= n_line_count;
        end
    end

endmodule

// ===== sv/ctt_queue.sv =====
// Short queue of per-byte result entries between the front and back ends.
// Uses ctt_pkg for the entry type and the status struct.
`timescale 1ns / 1ps

module ctt_queue import ctt_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_entry        i_entry,
    input  logic          i_pop,
    output t_entry        o_head,
    output t_queue_status o_status
);

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

    t_entry              r_slots [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic                do_push, do_pop;

    assign o_status.full  = (r_count == CNT_FULL);
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_slots[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ===== sv/ctt_back.sv =====
// Back end: unpacks queue entries into single results and drives the
// registered output channel. Uses ctt_pkg and ctt_out_if.
`timescale 1ns / 1ps

module ctt_back import ctt_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_queue_status i_status,
    input  t_entry        i_head,
    output logic          o_pop,
    ctt_out_if.source     o_out
);

    logic    r_valid;
    t_result r_result;
    logic    r_pend_valid;
    t_result r_pend;
    logic    load;

    // A held second result goes out before the queue is read again.
    assign load  = (!r_valid || o_out.ready) && (r_pend_valid || !i_status.empty);
    assign o_pop = load && !r_pend_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
            if (load) begin
                r_pend_valid <= !r_pend_valid && i_head.two;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result <= r_pend_valid ? r_pend : i_head.first;
            if (!r_pend_valid) begin
                r_pend <= i_head.second;
            end
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.kind         = r_result.kind;
    assign o_out.line_number  = r_result.line_number;
    assign o_out.start_column = r_result.start_column;
    assign o_out.length       = r_result.length;
    assign o_out.last_of_run  = r_result.last_of_run;

endmodule

// ===== sv/ctt_checker.sv =====
// Port-level checks of the token segmenter output, bound to the top level.
// Depends on ctt_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "char_class_token_segmenter_defines.svh"

module ctt_checker import ctt_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_kind,
    input logic [15:0] i_line_number,
    input logic [11:0] i_start_column,
    input logic [11:0] i_length,
    input logic        i_last_of_run
);

    logic line_end;

    assign line_end = i_out_valid && (i_kind == KIND_LINE_END);

    // A stalled item keeps its contents.
    `CTT_ASSERT_NEXT(a_hold_on_stall, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_kind) && $stable(i_line_number) &&
        $stable(i_start_column) && $stable(i_length) && $stable(i_last_of_run))

    `CTT_ASSERT_IMPL(a_kind_code, i_clk, i_rst_n, i_out_valid,
        i_kind == KIND_WORD || i_kind == KIND_SYMBOL || i_kind == KIND_LINE_END)

    `CTT_ASSERT_IMPL(a_line_end_len, i_clk, i_rst_n, line_end, i_length == '0)

    // A newline is always the last thing its byte reports.
    `CTT_ASSERT_IMPL(a_line_end_last, i_clk, i_rst_n, line_end, i_last_of_run)

endmodule

bind char_class_token_segmenter ctt_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_kind         (o_out.kind),
    .i_line_number  (o_out.line_number),
    .i_start_column (o_out.start_column),
    .i_length       (o_out.length),
    .i_last_of_run  (o_out.last_of_run)
);

// ===== bench/tb_top.sv =====
// Self-checking bench for char_class_token_segmenter: byte items in, token items out.
// Depends on ctt_pkg, the ctt_in_if/ctt_out_if interfaces and the segmenter RTL.
`timescale 1ns / 1ps

module tb_top;
    import ctt_pkg::*;

    localparam logic [11:0] COL_TOP   = 12'hFFF;
    localparam logic [15:0] LINE_TOP  = 16'hFFFF;
    localparam int          LIMIT     = 3_000_000;
    localparam int          HOLD_LEN  = 90;
    localparam int          MAX_PRINT = 200;

    typedef enum logic [1:0] {CLS_BLANK, CLS_WORD, CLS_SYMBOL} t_byte_cls;

    typedef struct {
        logic [7:0] ch;
        logic       eot;
        int         phase;
    } t_src_byte;

    logic i_clk;
    logic i_rst_n;

    ctt_in_if  in_if ();
    ctt_out_if out_if ();

    char_class_token_segmenter uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_src_byte text_bytes[$];
    t_result   pending_tokens[$];

    int send_idle_pct[3] = '{29, 78, 0};
    int recv_idle_pct[3] = '{78, 29, 0};
    int cur_phase   = 0;
    int hold_left   = 0;
    bit hold_done   = 0;
    int error_count = 0;
    int cycle_count = 0;

    // Tokenizer state, mirrored from what the block should hold.
    logic        run_open = 1'b0;
    logic        run_sym  = 1'b0;
    logic [11:0] run_col  = '0;
    logic [11:0] next_col = '0;
    logic [15:0] cur_line = '0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_byte_cls classify(input logic [7:0] b);
        logic [7:0] folded;
        folded = b | 8'h20;
        case (b)
            8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: return CLS_BLANK;
            CH_UNDERSCORE: return CLS_WORD;
            default: begin
                if ((b >= "0" && b <= "9") || (folded >= "a" && folded <= "z"))
                    return CLS_WORD;
                return CLS_SYMBOL;
            end
        endcase
    endfunction

    function automatic t_result make_token(input logic [1:0] kind, input logic [11:0] start,
                                           input logic [11:0] len);
        t_result t;
        t.kind         = kind;
        t.line_number  = cur_line;
        t.start_column = start;
        t.length       = len;
        t.last_of_run  = 1'b0;
        return t;
    endfunction

    // The end column can be one past the saturated column when the text ends on it.
    function automatic t_result close_run(input int end_col);
        int d;
        d = end_col - int'(run_col);
        if (d < 0)
            d = 0;
        if (d > int'(COL_TOP))
            d = int'(COL_TOP);
        return make_token(run_sym ? KIND_SYMBOL : KIND_WORD, run_col, d[11:0]);
    endfunction

    task automatic segment_byte(input logic [7:0] b, input logic eot);
        t_result   res[2];
        int        n;
        t_byte_cls cls;
        logic      sym;
        n   = 0;
        cls = classify(b);
        if (cls == CLS_BLANK) begin
            if (run_open) begin
                res[n] = close_run(int'(next_col));
                n++;
                run_open = 1'b0;
            end
            if (b == CH_NEWLINE) begin
                res[n] = make_token(KIND_LINE_END, next_col, '0);
                n++;
                next_col = '0;
                if (cur_line != LINE_TOP)
                    cur_line++;
            end else if (next_col != COL_TOP) begin
                next_col++;
            end
        end else begin
            sym = (cls == CLS_SYMBOL);
            if (run_open && sym != run_sym) begin
                res[n] = close_run(int'(next_col));
                n++;
                run_open = 1'b0;
            end
            if (!run_open) begin
                run_open = 1'b1;
                run_sym  = sym;
                run_col  = next_col;
            end
            if (eot) begin
                res[n] = close_run(int'(next_col) + 1);
                n++;
                run_open = 1'b0;
            end
            if (next_col != COL_TOP)
                next_col++;
        end
        if (n > 0)
            res[n-1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++)
            pending_tokens.push_back(res[i]);
        if (eot) begin
            run_open = 1'b0;
            run_sym  = 1'b0;
            run_col  = '0;
            next_col = '0;
            cur_line = '0;
        end
    endtask

    task automatic report_mismatch(input string what);
        if (error_count < MAX_PRINT)
            $display("[%0t] MISMATCH %s", $time, what);
        error_count++;
    endtask

    task automatic check_token(input t_result got);
        t_result want;
        if (pending_tokens.size() == 0) begin
            report_mismatch($sformatf("unexpected token kind=%0d line=%0d col=%0d len=%0d",
                                      got.kind, got.line_number, got.start_column,
                                      got.length));
            return;
        end
        want = pending_tokens.pop_front();
        if (got.kind !== want.kind)
            report_mismatch($sformatf("kind got %0d want %0d", got.kind, want.kind));
        if (got.line_number !== want.line_number)
            report_mismatch($sformatf("line_number got %0d want %0d",
                                      got.line_number, want.line_number));
        if (got.start_column !== want.start_column)
            report_mismatch($sformatf("start_column got %0d want %0d",
                                      got.start_column, want.start_column));
        if (got.length !== want.length)
            report_mismatch($sformatf("length got %0d want %0d", got.length, want.length));
        if (got.last_of_run !== want.last_of_run)
            report_mismatch($sformatf("last_of_run got %0d want %0d",
                                      got.last_of_run, want.last_of_run));
    endtask

    task automatic push_byte(input logic [7:0] b, input logic eot, input int ph);
        t_src_byte s;
        s.ch    = b;
        s.eot   = eot;
        s.phase = ph;
        text_bytes.push_back(s);
    endtask

    task automatic push_text(input string s, input logic eot_on_last, input int ph);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], eot_on_last && (i == s.len() - 1), ph);
    endtask

    // Mostly runs of one class split by blanks and newlines, with some raw noise bytes.
    task automatic fill_random(input int ph, input int count);
        logic [7:0] blanks[6];
        logic [7:0] b;
        int         made;
        int         pick;
        int         len;
        int         k;
        blanks = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
        made   = 0;
        while (made < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                len = $urandom_range(1, 6);
            else if (pick < 55)
                len = $urandom_range(1, 4);
            else if (pick < 75)
                len = $urandom_range(1, 2);
            else
                len = 1;
            for (int i = 0; i < len; i++) begin
                if (pick < 35) begin
                    k = $urandom_range(0, 62);
                    if (k < 10)
                        b = 8'("0" + k);
                    else if (k < 36)
                        b = 8'("A" + k - 10);
                    else if (k < 62)
                        b = 8'("a" + k - 36);
                    else
                        b = CH_UNDERSCORE;
                end else if (pick < 55) begin
                    do
                        b = 8'($urandom_range(0, 255));
                    while (classify(b) != CLS_SYMBOL);
                end else if (pick < 75) begin
                    b = blanks[$urandom_range(0, 5)];
                end else if (pick < 82) begin
                    b = CH_NEWLINE;
                end else begin
                    b = 8'($urandom_range(0, 255));
                end
                push_byte(b, $urandom_range(0, 59) == 0, ph);
                made++;
            end
        end
    endtask

    // Sender: one item offered at a time, held until the block takes it.
    always @(posedge i_clk) begin : drive_bytes
        t_src_byte nxt;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready)
                segment_byte(in_if.ch, in_if.end_of_text);
            if (!in_if.valid || in_if.ready) begin
                if (text_bytes.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct[text_bytes[0].phase]) begin
                    nxt = text_bytes.pop_front();
                    in_if.valid       <= 1'b1;
                    in_if.ch          <= nxt.ch;
                    in_if.end_of_text <= nxt.eot;
                    cur_phase         <= nxt.phase;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each accepted token and throttles ready.
    always @(posedge i_clk) begin : watch_tokens
        t_result got;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                got.kind         = out_if.kind;
                got.line_number  = out_if.line_number;
                got.start_column = out_if.start_column;
                got.length       = out_if.length;
                got.last_of_run  = out_if.last_of_run;
                check_token(got);
            end
            out_if.ready <= (hold_left == 0) &&
                            ($urandom_range(0, 99) >= recv_idle_pct[cur_phase]);
        end
    end

    // One long receiver stall as the last phase starts, so the result queue backs up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (cur_phase == 2 && !hold_done) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("char_class_token_segmenter regression: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.ch          = '0;
        in_if.end_of_text = 1'b0;
        out_if.ready      = 1'b0;

        // Directed: every byte class and blank, the byte extremes, class changes,
        // a newline closing a run, and the end of text on symbol, blank and newline.
        push_text("Az_09!?", 1'b0, 0);
        push_byte(8'h09, 1'b0, 0);
        push_byte(8'h00, 1'b0, 0);
        push_byte(8'h80, 1'b0, 0);
        push_byte(8'hFF, 1'b0, 0);
        push_byte(8'h0B, 1'b0, 0);
        push_text("zZ", 1'b0, 0);
        push_byte(CH_NEWLINE, 1'b0, 0);
        push_byte(8'h0C, 1'b0, 0);
        push_byte(8'h0D, 1'b0, 0);
        push_byte(CH_NEWLINE, 1'b0, 0);
        push_text("a+", 1'b1, 0);
        push_text("x ", 1'b1, 0);
        push_text("q", 1'b0, 0);
        push_byte(CH_NEWLINE, 1'b1, 0);
        push_byte(8'h7F, 1'b1, 0);

        fill_random(0, 400);
        fill_random(1, 400);
        fill_random(2, 400);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (text_bytes.size() != 0 || in_if.valid || pending_tokens.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (error_count == 0)
            $display("char_class_token_segmenter regression: pass");
        else
            $display("char_class_token_segmenter regression: fail");
        $finish;
    end

endmodule
